>>> hdl/assert_macros.svh
// Assertion macros for the keyboard-to-ASCII FIFO core.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The condition must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/hbk_pkg.sv
// Package: item types, constants and keycode-to-ASCII tables.
package hbk_pkg;

    localparam int KEY_SLOTS = 6;

    localparam logic CMD_REPORT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    localparam int MOD_LSHIFT_BIT = 1;
    localparam int MOD_RSHIFT_BIT = 5;

    localparam logic [6:0] ASCII_NUL = 7'h00;
    localparam logic [6:0] ASCII_BS  = 7'h08;
    localparam logic [6:0] ASCII_TAB = 7'h09;
    localparam logic [6:0] ASCII_LF  = 7'h0A;
    localparam logic [6:0] ASCII_ESC = 7'h1B;
    localparam logic [6:0] ASCII_DEL = 7'h7F;

    typedef struct packed {
        logic       command;
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
    } req_item_t;

    typedef struct packed {
        logic [6:0] char_out;
        logic       char_valid;
        logic [2:0] queued_count;
        logic [2:0] dropped_count;
        logic [5:0] fill_level;
        logic       not_empty;
    } rsp_item_t;

    typedef logic [KEY_SLOTS-1:0][7:0] key_row_t;

    // New characters of one report, packed toward entry 0 in slot order.
    typedef struct packed {
        logic [2:0]                count;
        logic [KEY_SLOTS-1:0][6:0] chars;
    } hbk_chars_t;

    // US layout, no shift.
    function automatic logic [6:0] plain_ascii(input logic [6:0] key);
        logic [6:0] ch;
        ch = ASCII_NUL;
        case (key) inside
            [7'd4:7'd29]:  ch = 7'h61 + (key - 7'd4);
            [7'd30:7'd38]: ch = 7'h31 + (key - 7'd30);
            7'd39:         ch = 7'h30;
            7'd40:         ch = ASCII_LF;
            7'd41:         ch = ASCII_ESC;
            7'd42:         ch = ASCII_BS;
            7'd43:         ch = ASCII_TAB;
            7'd44:         ch = 7'h20;
            7'd45:         ch = 7'h2D;
            7'd46:         ch = 7'h3D;
            7'd47:         ch = 7'h5B;
            7'd48:         ch = 7'h5D;
            7'd49:         ch = 7'h5C;
            7'd50:         ch = 7'h23;
            7'd51:         ch = 7'h3B;
            7'd52:         ch = 7'h27;
            7'd53:         ch = 7'h60;
            7'd54:         ch = 7'h2C;
            7'd55:         ch = 7'h2E;
            7'd56:         ch = 7'h2F;
            7'd76:         ch = ASCII_DEL;
            7'd92:         ch = 7'h2F;
            7'd93:         ch = 7'h2A;
            7'd94:         ch = 7'h2D;
            7'd95:         ch = 7'h2B;
            7'd96:         ch = ASCII_LF;
            [7'd97:7'd105]: ch = 7'h31 + (key - 7'd97);
            7'd106:        ch = 7'h30;
            7'd107:        ch = 7'h2E;
            default:       ch = ASCII_NUL;
        endcase
        return ch;
    endfunction

    // US layout with shift; keys that shift does not change fall back to plain.
    function automatic logic [6:0] shift_ascii(input logic [6:0] key);
        logic [6:0] ch;
        ch = plain_ascii(key);
        case (key) inside
            [7'd4:7'd29]: ch = 7'h41 + (key - 7'd4);
            7'd30:        ch = 7'h21;
            7'd31:        ch = 7'h40;
            7'd32:        ch = 7'h23;
            7'd33:        ch = 7'h24;
            7'd34:        ch = 7'h25;
            7'd35:        ch = 7'h5E;
            7'd36:        ch = 7'h26;
            7'd37:        ch = 7'h2A;
            7'd38:        ch = 7'h28;
            7'd39:        ch = 7'h29;
            7'd45:        ch = 7'h5F;
            7'd46:        ch = 7'h2B;
            7'd47:        ch = 7'h7B;
            7'd48:        ch = 7'h7D;
            7'd49:        ch = 7'h7C;
            7'd50:        ch = 7'h7E;
            7'd51:        ch = 7'h3A;
            7'd52:        ch = 7'h22;
            7'd53:        ch = 7'h7E;
            7'd54:        ch = 7'h3C;
            7'd55:        ch = 7'h3E;
            7'd56:        ch = 7'h3F;
            default:      ch = ch;
        endcase
        return ch;
    endfunction

endpackage

>>> hdl/hbk_ram.sv
// Generic single-port-write, registered-read RAM.
module hbk_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/hbk_decode.sv
// Report decoder: new-press detection, ASCII lookup and slot-order packing.
module hbk_decode
    import hbk_pkg::*;
(
    input  logic [7:0] modifiers,
    input  key_row_t   keys,
    input  key_row_t   prev_keys,
    output hbk_chars_t chars
);

    logic                      shifted;
    logic [KEY_SLOTS-1:0]      push;
    logic [KEY_SLOTS-1:0][6:0] code;

    assign shifted = modifiers[MOD_LSHIFT_BIT] | modifiers[MOD_RSHIFT_BIT];

    always_comb
    begin
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            logic held;
            held = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++)
            begin
                if (prev_keys[j] == keys[i])
                begin
                    held = 1'b1;
                end
            end
            code[i] = shifted ? shift_ascii(keys[i][6:0]) : plain_ascii(keys[i][6:0]);
            // Keycodes of 128 and above never map to a character.
            push[i] = (keys[i] != 8'd0) && !keys[i][7] && !held && (code[i] != ASCII_NUL);
        end
    end

    // Pack pushed characters toward entry 0 in slot order.
    always_comb
    begin
        logic [2:0] pos;
        pos         = 3'd0;
        chars.chars = '0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            for (int p = 0; p < KEY_SLOTS; p++)
            begin
                if (push[i] && (pos == 3'(p)))
                begin
                    chars.chars[p] = code[i];
                end
            end
            pos = pos + 3'(push[i]);
        end
        chars.count = pos;
    end

endmodule

>>> hdl/hid_boot_keyboard_to_ascii_fifo_core.sv
// Top level: boot keyboard reports in, ASCII FIFO status and popped characters out.
//
//  Channel | Handshake            | Payload     | Direction
//  --------+----------------------+-------------+----------
//  req     | req_valid, req_stall | req_item_t  | in
//  rsp     | rsp_valid, rsp_stall | rsp_item_t  | out
//
// An item waits in the input register until the write port is drained and the
// result slot frees, then its result is loaded into the result register; a pop
// or a report that queues nothing leaves nothing to drain. A report that queues
// n characters holds the next item until all n are written, since the character
// RAM takes one write per cycle. One result per item, in order. Reset clears the
// stored keys and both ring pointers; the RAM is not cleared. A stalled result
// holds while one more item waits in the input register.
module hid_boot_keyboard_to_ascii_fifo_core
    import hbk_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

`include "assert_macros.svh"

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = AW + 3;
    localparam logic [AW:0]   DEPTH_W = (AW+1)'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);

    // Input register
    logic      in_vld_reg, in_vld_next;
    req_item_t in_item_reg;

    // Result register
    logic       out_vld_reg, out_vld_next;
    logic       res_char_valid_reg;
    logic [2:0] res_queued_reg;
    logic [2:0] res_dropped_reg;
    logic [5:0] res_fill_reg;
    logic       res_not_empty_reg;

    // Ring state
    key_row_t      prev_keys_reg, prev_keys_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;

    // Characters waiting for the RAM write port
    logic [KEY_SLOTS-1:0][6:0] pend_reg, pend_next;
    logic [2:0]                pend_cnt_reg, pend_cnt_next;
    logic [AW-1:0]             wr_addr_reg, wr_addr_next;

    logic          advance;
    logic          is_pop;
    logic          pop_ok;
    key_row_t      keys;
    hbk_chars_t    dec;
    logic [AW:0]   fill_wide;
    logic [AW-1:0] fill;
    logic [AW-1:0] free_slots;
    logic [2:0]    queued;
    logic [2:0]    dropped;
    logic [AW:0]   wsum;
    logic [AW:0]   wwrap;
    logic [AW-1:0] fill_after;
    logic [AW+5:0] fill_ext;
    logic          ram_wr_en;
    logic          ram_rd_en;
    logic [6:0]    ram_rdata;

    // Move the held item on once the write port is drained and the result slot frees.
    assign advance   = in_vld_reg && (pend_cnt_reg == 3'd0) && (!out_vld_reg || !rsp_stall);
    assign req_stall = in_vld_reg && !advance;
    assign rsp_valid = out_vld_reg;

    assign keys = {in_item_reg.key_slot_5, in_item_reg.key_slot_4, in_item_reg.key_slot_3,
                   in_item_reg.key_slot_2, in_item_reg.key_slot_1, in_item_reg.key_slot_0};

    hbk_decode u_decode (
        .modifiers (in_item_reg.modifiers),
        .keys      (keys),
        .prev_keys (prev_keys_reg),
        .chars     (dec)
    );

    // Occupancy and space from the logical pointers.
    always_comb
    begin
        if (wptr_reg >= rptr_reg)
        begin
            fill_wide = {1'b0, wptr_reg} - {1'b0, rptr_reg};
        end
        else
        begin
            fill_wide = DEPTH_W - {1'b0, rptr_reg} + {1'b0, wptr_reg};
        end
        fill       = fill_wide[AW-1:0];
        free_slots = LAST_PTR - fill;
        is_pop     = (in_item_reg.command == CMD_POP);
        pop_ok     = is_pop && (fill != '0);
        // Push in slot order until full; the rest are dropped.
        queued     = (CW'(free_slots) < CW'(dec.count)) ? 3'(free_slots) : dec.count;
        dropped    = dec.count - queued;
        wsum       = {1'b0, wptr_reg} + (AW+1)'(queued);
        wwrap      = (wsum >= DEPTH_W) ? (wsum - DEPTH_W) : wsum;
        if (is_pop)
        begin
            fill_after = pop_ok ? (fill - AW'(1)) : fill;
        end
        else
        begin
            fill_after = fill + AW'(queued);
        end
        fill_ext = {6'd0, fill_after};
    end

    // Next-state logic for handshake, ring and write-drain state.
    always_comb
    begin
        in_vld_next    = in_vld_reg;
        out_vld_next   = out_vld_reg;
        prev_keys_next = prev_keys_reg;
        wptr_next      = wptr_reg;
        rptr_next      = rptr_reg;
        pend_next      = pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        wr_addr_next   = wr_addr_reg;

        if (req_valid && !req_stall)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_vld_next = 1'b0;
        end

        // Drain one waiting character per cycle.
        if (pend_cnt_reg != 3'd0)
        begin
            for (int k = 0; k < KEY_SLOTS - 1; k++)
            begin
                pend_next[k] = pend_reg[k+1];
            end
            pend_cnt_next = pend_cnt_reg - 3'd1;
            wr_addr_next  = (wr_addr_reg == LAST_PTR) ? '0 : (wr_addr_reg + AW'(1));
        end

        if (advance)
        begin
            if (is_pop)
            begin
                if (pop_ok)
                begin
                    rptr_next = (rptr_reg == LAST_PTR) ? '0 : (rptr_reg + AW'(1));
                end
            end
            else
            begin
                prev_keys_next = keys;
                wptr_next      = wwrap[AW-1:0];
                pend_next      = dec.chars;
                pend_cnt_next  = queued;
                wr_addr_next   = wptr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
            prev_keys_reg <= '0;
            wptr_reg      <= '0;
            rptr_reg      <= '0;
            pend_cnt_reg  <= 3'd0;
        end
        else
        begin
            in_vld_reg    <= in_vld_next;
            out_vld_reg   <= out_vld_next;
            prev_keys_reg <= prev_keys_next;
            wptr_reg      <= wptr_next;
            rptr_reg      <= rptr_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_item_reg <= req;
        end
        if (advance)
        begin
            res_char_valid_reg <= pop_ok;
            res_queued_reg     <= is_pop ? 3'd0 : queued;
            res_dropped_reg    <= is_pop ? 3'd0 : dropped;
            res_fill_reg       <= fill_ext[5:0];
            res_not_empty_reg  <= (fill_after != '0);
        end
        pend_reg    <= pend_next;
        wr_addr_reg <= wr_addr_next;
    end

    // Read only when a pop moves into the result slot, so the data holds under stall.
    assign ram_wr_en = (pend_cnt_reg != 3'd0);
    assign ram_rd_en = advance && pop_ok;

    hbk_ram #(
        .WIDTH (7),
        .DEPTH (FIFO_DEPTH)
    ) u_char_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (pend_reg[0]),
        .rd_en   (ram_rd_en),
        .rd_addr (rptr_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        rsp.char_out      = res_char_valid_reg ? ram_rdata : ASCII_NUL;
        rsp.char_valid    = res_char_valid_reg;
        rsp.queued_count  = res_queued_reg;
        rsp.dropped_count = res_dropped_reg;
        rsp.fill_level    = res_fill_reg;
        rsp.not_empty     = res_not_empty_reg;
    end

    `ASSERT_IMPLIES(a_no_pop_before_drain, ram_rd_en, (pend_cnt_reg == 3'd0) && (wptr_reg != rptr_reg), "pop issued while characters still wait for the RAM")
    `ASSERT_ALWAYS(a_fill_in_range, fill <= LAST_PTR, "ring holds more than depth minus one")
    `ASSERT_IMPLIES(a_counts_split, advance && !is_pop, (3'(queued + dropped) == dec.count), "queued plus dropped differs from new presses")
    `ASSERT_NEXT(a_drain_step, (pend_cnt_reg != 3'd0), (pend_cnt_reg == $past(pend_cnt_reg) - 3'd1), "write drain skipped or stalled")

endmodule

>>> dv/tb_top.sv
// Self-checking bench for the boot keyboard report to ASCII FIFO core.
`timescale 1ns / 1ps

module tb_top
    import hbk_pkg::*;
();

    localparam int RING_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int MAX_SHOWN   = 100;
    localparam int REQ_W       = $bits(req_item_t);

    // Keyboard-to-ASCII predictor: own copy of the held keys and the ring.
    // Each accepted item queues the result the block must produce for it.
    class kbd_ascii_board;
        logic [7:0]  held_keys[KEY_SLOTS];
        logic [6:0]  ring[RING_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        logic [6:0]  plain_tbl[128];
        logic [6:0]  upper_tbl[128];
        rsp_item_t   expected_rsp[$];
        int          errors;

        function new();
            string digits, digits_up, punct, punct_up, keypad;
            digits    = "1234567890";
            digits_up = "!@#$%^&*()";
            punct     = "-=[]\\#;'`,./";
            punct_up  = "_+{}|~:\"~<>?";
            keypad    = "/*-+\n1234567890.";
            foreach (plain_tbl[k])
                plain_tbl[k] = ASCII_NUL;
            for (int k = 0; k < 26; k++)
                plain_tbl[4 + k] = 7'h61 + k[6:0];
            for (int k = 0; k < 10; k++)
                plain_tbl[30 + k] = 7'(digits[k]);
            plain_tbl[40] = ASCII_LF;
            plain_tbl[41] = ASCII_ESC;
            plain_tbl[42] = ASCII_BS;
            plain_tbl[43] = ASCII_TAB;
            plain_tbl[44] = 7'h20;
            for (int k = 0; k < 12; k++)
                plain_tbl[45 + k] = 7'(punct[k]);
            plain_tbl[76] = ASCII_DEL;
            for (int k = 0; k < 16; k++)
                plain_tbl[92 + k] = 7'(keypad[k]);
            // Shift changes letters, the digit row and punctuation only.
            upper_tbl = plain_tbl;
            for (int k = 0; k < 26; k++)
                upper_tbl[4 + k] = 7'h41 + k[6:0];
            for (int k = 0; k < 10; k++)
                upper_tbl[30 + k] = 7'(digits_up[k]);
            for (int k = 0; k < 12; k++)
                upper_tbl[45 + k] = 7'(punct_up[k]);
            foreach (held_keys[s])
                held_keys[s] = 8'h00;
            wr_ptr = 0;
            rd_ptr = 0;
            errors = 0;
        endfunction

        function int unsigned bump(int unsigned p);
            return (p + 1 >= RING_DEPTH) ? 0 : p + 1;
        endfunction

        function void note_request(req_item_t it);
            rsp_item_t   exp;
            logic [7:0]  keys[KEY_SLOTS];
            logic [6:0]  ch;
            bit          shifted;
            bit          held;
            int unsigned fill;
            exp = '0;
            if (it.command == CMD_POP)
            begin
                if (wr_ptr != rd_ptr)
                begin
                    exp.char_out   = ring[rd_ptr];
                    exp.char_valid = 1'b1;
                    rd_ptr         = bump(rd_ptr);
                end
            end
            else
            begin
                keys = '{it.key_slot_0, it.key_slot_1, it.key_slot_2,
                         it.key_slot_3, it.key_slot_4, it.key_slot_5};
                shifted = it.modifiers[MOD_LSHIFT_BIT] || it.modifiers[MOD_RSHIFT_BIT];
                foreach (keys[s])
                begin
                    if (keys[s] == 8'h00 || keys[s][7])
                        continue;
                    held = 1'b0;
                    foreach (held_keys[p])
                        if (held_keys[p] == keys[s])
                            held = 1'b1;
                    if (held)
                        continue;
                    ch = shifted ? upper_tbl[keys[s][6:0]] : plain_tbl[keys[s][6:0]];
                    if (ch == ASCII_NUL)
                        continue;
                    if (bump(wr_ptr) != rd_ptr)
                    begin
                        ring[wr_ptr]      = ch;
                        wr_ptr            = bump(wr_ptr);
                        exp.queued_count  = exp.queued_count + 3'd1;
                    end
                    else
                        exp.dropped_count = exp.dropped_count + 3'd1;
                end
                held_keys = keys;
            end
            fill           = (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
            exp.fill_level = fill[5:0];
            exp.not_empty  = (fill != 0);
            expected_rsp.push_back(exp);
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_SHOWN)
                $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(rsp_item_t got);
            rsp_item_t exp;
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
                return;
            end
            exp = expected_rsp.pop_front();
            if (got.char_out !== exp.char_out)
                report_mismatch($sformatf("char_out %h, want %h", got.char_out, exp.char_out));
            if (got.char_valid !== exp.char_valid)
                report_mismatch($sformatf("char_valid %b, want %b",
                                          got.char_valid, exp.char_valid));
            if (got.queued_count !== exp.queued_count)
                report_mismatch($sformatf("queued_count %0d, want %0d",
                                          got.queued_count, exp.queued_count));
            if (got.dropped_count !== exp.dropped_count)
                report_mismatch($sformatf("dropped_count %0d, want %0d",
                                          got.dropped_count, exp.dropped_count));
            if (got.fill_level !== exp.fill_level)
                report_mismatch($sformatf("fill_level %0d, want %0d",
                                          got.fill_level, exp.fill_level));
            if (got.not_empty !== exp.not_empty)
                report_mismatch($sformatf("not_empty %b, want %b", got.not_empty, exp.not_empty));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    kbd_ascii_board board;

    // Idling knobs: a calm side never inserts gaps or stalls.
    bit         calm_tx;
    bit         calm_rx;
    int         stall_run;
    int         cycle_cnt;
    logic [7:0] typed[KEY_SLOTS];

    hid_boot_keyboard_to_ascii_fifo_core #(
        .FIFO_DEPTH(RING_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Keycode for the typing model: mostly mapped keys, some unmapped,
    // some at 128 and above, some empty slots.
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78)
            return 8'($urandom_range(4, 56));
        if (r < 86)
            return 8'($urandom_range(84, 107));
        if (r < 90)
            return 8'($urandom_range(57, 127));
        if (r < 95)
            return 8'($urandom_range(128, 255));
        return 8'h00;
    endfunction

    // Present one item, hold it until the block takes it, then record it.
    // Valid stays high into the next item when no gap is drawn.
    task automatic send_item(input req_item_t it);
        int gap;
        gap = calm_tx ? 0 : gap_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req       <= it;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(it);
    endtask

    task automatic send_report(input logic [7:0] mods, input logic [7:0] k0,
                               input logic [7:0] k1, input logic [7:0] k2,
                               input logic [7:0] k3, input logic [7:0] k4,
                               input logic [7:0] k5);
        req_item_t it;
        it = '{command: CMD_REPORT, modifiers: mods, key_slot_0: k0, key_slot_1: k1,
               key_slot_2: k2, key_slot_3: k3, key_slot_4: k4, key_slot_5: k5};
        send_item(it);
    endtask

    task automatic send_pop();
        req_item_t it;
        it         = '0;
        it.command = CMD_POP;
        send_item(it);
    endtask

    // Result side: check every accepted result, then draw the next stall.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp);
        if (!rst_n || calm_rx)
        begin
            rsp_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
        begin
            rsp_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if ($urandom_range(0, 99) < 30)
        begin
            rsp_stall <= 1'b1;
            stall_run <= gap_len();
        end
        else
            rsp_stall <= 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        req_item_t it;
        int        pop_pct;
        int        waited;

        board     = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        calm_tx   = 1'b0;
        calm_rx   = 1'b0;
        foreach (typed[s])
            typed[s] = 8'h00;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        // Pop on an empty ring, then an all-empty report.
        send_pop();
        send_report(8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        // Left shift letters, then the same keys held under right shift.
        send_report(8'h02, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        send_report(8'h20, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9);
        // Plain: last letter, digits, newline, escape, backspace.
        send_report(8'h00, 8'd29, 8'd30, 8'd39, 8'd40, 8'd41, 8'd42);
        // Many modifier bits set but neither shift bit, then all modifier bits set.
        send_report(8'hDD, 8'd43, 8'd44, 8'd45, 8'd46, 8'd47, 8'd48);
        send_report(8'hFF, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54);
        // Delete, an unmapped key and keycodes of 128 and above.
        send_report(8'h22, 8'd55, 8'd56, 8'd76, 8'd57, 8'h80, 8'hFF);
        // Keycodes of 128 and above held over, keypad keys.
        send_report(8'h00, 8'h80, 8'hFF, 8'd92, 8'd93, 8'd94, 8'd95);
        // Repeated keycode in one report pushes once per slot.
        send_report(8'h00, 8'd31, 8'd31, 8'd31, 8'd96, 8'd97, 8'd0);
        send_report(8'h20, 8'd104, 8'd105, 8'd106, 8'd107, 8'd31, 8'd127);
        send_pop();
        send_pop();
        send_pop();
        // Alternate two key sets until the ring is full and reports drop.
        for (int n = 0; n < 10; n++)
        begin
            if (n % 2 == 0)
                send_report(8'h00, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15);
            else
                send_report(8'h02, 8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21);
        end
        send_pop();
        send_pop();

        // Random part: phases cycle through filling, draining and mixed traffic on the ring.
        for (int ph = 0; ph < 14; ph++)
        begin
            pop_pct = (ph % 3 == 0) ? 10 : ((ph % 3 == 1) ? 85 : 45);
            calm_tx = (ph % 4 == 3);
            calm_rx = (ph % 5 == 2);
            for (int n = 0; n < 100; n++)
            begin
                it = req_item_t'(REQ_W'({$urandom, $urandom}));
                if ($urandom_range(0, 99) < pop_pct)
                    it.command = CMD_POP;
                else
                begin
                    it.command = CMD_REPORT;
                    // Most reports follow a typing pattern: release or press a
                    // few keys and hold the rest; the others stay random bytes.
                    if ($urandom_range(0, 4) != 0)
                    begin
                        foreach (typed[s])
                        begin
                            case ($urandom_range(0, 9))
                                0, 1, 2: typed[s] = 8'h00;
                                3, 4, 5: typed[s] = pick_key();
                                default: typed[s] = typed[s];
                            endcase
                        end
                        if ($urandom_range(0, 1) == 0)
                        begin
                            it.modifiers[MOD_LSHIFT_BIT] = 1'b0;
                            it.modifiers[MOD_RSHIFT_BIT] = 1'b0;
                        end
                        it.key_slot_0 = typed[0];
                        it.key_slot_1 = typed[1];
                        it.key_slot_2 = typed[2];
                        it.key_slot_3 = typed[3];
                        it.key_slot_4 = typed[4];
                        it.key_slot_5 = typed[5];
                    end
                end
                send_item(it);
            end
        end
        req_valid <= 1'b0;

        // Drain: wait for every outstanding result, then a few spare cycles.
        waited = 0;
        while (board.expected_rsp.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (board.expected_rsp.size() != 0)
            board.report_mismatch($sformatf("%0d results never arrived",
                                            board.expected_rsp.size()));

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/hbk_pkg.sv
hdl/hbk_ram.sv
hdl/hbk_decode.sv
hdl/hid_boot_keyboard_to_ascii_fifo_core.sv
dv/tb_top.sv
